/* rtl/sssd_pkg.sv */
// shared types, constants and segment lookup for the seven segment scan driver
// no dependencies; imported by every module of the block
`default_nettype none

package sssd_pkg;

  // scan positions
  localparam logic [1:0] SLOT_THOUSANDS = 2'd0;
  localparam logic [1:0] SLOT_HUNDREDS  = 2'd1;
  localparam logic [1:0] SLOT_TENS      = 2'd2;
  localparam logic [1:0] SLOT_UNITS     = 2'd3;

  // one-hot digit selects
  localparam logic [7:0] SEL_SLOT0 = 8'h80;
  localparam logic [7:0] SEL_SLOT1 = 8'h40;
  localparam logic [7:0] SEL_SLOT2 = 8'h20;
  localparam logic [7:0] SEL_SLOT3 = 8'h10;

  localparam logic [7:0] SEG_MINUS = 8'h02;
  localparam logic [7:0] SEG_DOT   = 8'h01;

  localparam logic [7:0] BLINK_HALF_RESET = 8'd25;

  // reciprocals for constant division, exact for values up to 16384
  localparam logic [15:0] RECIP_10   = 16'd52429;  // shift 19
  localparam logic [15:0] RECIP_100  = 16'd41944;  // shift 22
  localparam logic [15:0] RECIP_1000 = 16'd16778;  // shift 24
  // divide by ten for values below 1024, shift 11
  localparam logic [7:0]  RECIP_10_SMALL = 8'd205;

  typedef struct packed {
    logic [14:0] temp;
    logic [6:0]  value;  // hours or minutes for this slot
    logic [1:0]  slot;
    logic        dot;    // separator dot lit
  } sssd_in_t;

  typedef struct packed {
    logic [14:0] quot;   // magnitude divided by the slot's power of ten
    logic [6:0]  value;
    logic [1:0]  slot;
    logic        dot;
    logic        neg;
  } sssd_mid_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hfc;
      4'd1: s = 8'h60;
      4'd2: s = 8'hda;
      4'd3: s = 8'hf2;
      4'd4: s = 8'h66;
      4'd5: s = 8'hb6;
      4'd6: s = 8'hbe;
      4'd7: s = 8'he0;
      4'd8: s = 8'hfe;
      4'd9: s = 8'hf6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/sssd_if.sv */
// valid/ready channel interfaces for scan ticks and display transactions
// no dependencies
`default_nettype none

interface sssd_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] temp_tenths;
  logic [6:0]  hours;
  logic [5:0]  minutes;
  logic        running;

  modport source (output valid, output temp_tenths, output hours, output minutes,
                  output running, input ready);
  modport sink (input valid, input temp_tenths, input hours, input minutes,
                input running, output ready);
endinterface

interface sssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_select;
  logic [7:0] upper_segments;
  logic [7:0] lower_segments;

  modport source (output valid, output digit_select, output upper_segments,
                  output lower_segments, input ready);
  modport sink (input valid, input digit_select, input upper_segments,
                input lower_segments, output ready);
endinterface

`default_nettype wire

/* rtl/sssd_scale.sv */
// magnitude and power-of-ten scaling stage
// depends on sssd_pkg
`default_nettype none

module sssd_scale
  import sssd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sssd_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output sssd_mid_t      out_data
);

  logic        neg;
  logic [14:0] mag;
  logic [15:0] recip;
  logic [31:0] prod;
  logic [14:0] quot;

  always_comb begin
    neg = in_data.temp[14];
    mag = neg ? (15'd0 - in_data.temp) : in_data.temp;
    case (in_data.slot)
      SLOT_THOUSANDS: recip = RECIP_1000;
      SLOT_HUNDREDS:  recip = RECIP_100;
      SLOT_TENS:      recip = RECIP_10;
      default:        recip = 16'd0;
    endcase
    prod = {17'd0, mag} * {16'd0, recip};
    case (in_data.slot)
      SLOT_THOUSANDS: quot = 15'(prod >> 24);
      SLOT_HUNDREDS:  quot = 15'(prod >> 22);
      SLOT_TENS:      quot = 15'(prod >> 19);
      default:        quot = mag;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.quot  <= quot;
      out_data.value <= in_data.value;
      out_data.slot  <= in_data.slot;
      out_data.dot   <= in_data.dot;
      out_data.neg   <= neg;
    end
  end

endmodule

`default_nettype wire

/* rtl/sssd_encode.sv */
// digit extraction, segment encoding and output register
// depends on sssd_pkg and sssd_out_if
`default_nettype none

module sssd_encode
  import sssd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sssd_mid_t in_data,
  sssd_out_if.source     disp
);

  logic [31:0] qprod;
  logic [14:0] qdiv;
  logic [14:0] qdiv10;
  logic [3:0]  temp_digit;
  logic [14:0] vprod;
  logic [3:0]  vtens;
  logic [6:0]  vtens10;
  logic [3:0]  vunits;
  logic [3:0]  vtens_digit;
  logic [7:0]  temp_seg;
  logic [7:0]  sel;
  logic [7:0]  upper;
  logic [7:0]  lower;

  always_comb begin
    // quotient mod ten
    qprod      = {17'd0, in_data.quot} * {16'd0, RECIP_10};
    qdiv       = 15'(qprod >> 19);
    qdiv10     = 15'({qdiv, 3'b000}) + 15'({qdiv, 1'b0});
    temp_digit = 4'(in_data.quot - qdiv10);
    temp_seg   = seg_of(temp_digit);

    // time digits: tens of (value mod 100) and units
    vprod       = {8'd0, in_data.value} * {7'd0, RECIP_10_SMALL};
    vtens       = 4'(vprod >> 11);
    vtens10     = 7'({vtens, 3'b000}) + 7'({vtens, 1'b0});
    vunits      = 4'(in_data.value - vtens10);
    vtens_digit = (vtens >= 4'd10) ? (vtens - 4'd10) : vtens;

    case (in_data.slot)
      SLOT_THOUSANDS: begin
        sel   = SEL_SLOT0;
        upper = in_data.neg ? SEG_MINUS : temp_seg;
        lower = seg_of(vtens_digit);
      end
      SLOT_HUNDREDS: begin
        sel   = SEL_SLOT1;
        upper = temp_seg;
        lower = seg_of(vunits) | (in_data.dot ? SEG_DOT : 8'h00);
      end
      SLOT_TENS: begin
        sel   = SEL_SLOT2;
        upper = temp_seg | SEG_DOT;
        lower = seg_of(vtens_digit);
      end
      default: begin
        sel   = SEL_SLOT3;
        upper = temp_seg;
        lower = seg_of(vunits) | (in_data.dot ? SEG_DOT : 8'h00);
      end
    endcase
  end

  assign in_ready = !disp.valid || disp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp.valid <= 1'b0;
    end else if (in_ready) begin
      disp.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      disp.digit_select   <= sel;
      disp.upper_segments <= upper;
      disp.lower_segments <= lower;
    end
  end

endmodule

`default_nettype wire

/* rtl/seven_segment_scan_driver_unit.sv */
// seven segment scan driver: an accepted tick transaction passes the input register,
// scaling register and output register to become its display transaction; one tick
// per cycle while the display side takes them; each stage is a valid/ready register
// that refills while its content is taken, so a stalled output only holds the pipe
// reset (rst, synchronous): scan slot, frame count and blink phase cleared,
// blink half period set to 25, all stages emptied
`default_nettype none

module seven_segment_scan_driver_unit
  import sssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  sssd_in_if.sink         tick,
  sssd_out_if.source      disp
);

  // scan and blink state
  logic [7:0] blink_half_period;
  logic [1:0] scan_slot;
  logic [7:0] frame_count;
  logic       blink_phase;

  logic [7:0] frame_count_next;
  logic       blink_phase_next;

  // input register
  logic       in_valid;
  sssd_in_t   in_data;
  logic       scale_ready;

  // scaling stage to encoder
  logic       mid_valid;
  logic       mid_ready;
  sssd_mid_t  mid_data;

  logic       accept;
  logic       blinking;
  logic       dot_lit;
  logic [7:0] limit;
  logic [8:0] frame_inc;

  assign accept     = tick.valid && tick.ready;
  // input register frees up when empty or when its transaction moves on
  assign tick.ready = !in_valid || scale_ready;

  // dots drop only while running with a nonzero time and in the dark phase
  assign blinking = tick.running && ((tick.hours != 7'd0) || (tick.minutes != 6'd0));
  assign dot_lit  = !(blinking && blink_phase);

  // a half period of zero behaves as one frame
  assign limit     = (blink_half_period == 8'd0) ? 8'd1 : blink_half_period;
  assign frame_inc = {1'b0, frame_count} + 9'd1;

  always_comb begin
    frame_count_next = frame_count;
    blink_phase_next = blink_phase;
    // frame ends after the last slot
    if (scan_slot == SLOT_UNITS) begin
      if (frame_inc >= {1'b0, limit}) begin
        frame_count_next = 8'd0;
        blink_phase_next = !blink_phase;
      end else begin
        frame_count_next = frame_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_half_period <= BLINK_HALF_RESET;
    end else if (cfg_wr_en) begin
      blink_half_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_slot   <= SLOT_THOUSANDS;
      frame_count <= 8'd0;
      blink_phase <= 1'b0;
    end else if (accept) begin
      scan_slot   <= scan_slot + 2'd1;
      frame_count <= frame_count_next;
      blink_phase <= blink_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  // capture the transaction with its slot and dot decision
  always_ff @(posedge clk) begin
    if (accept) begin
      in_data.temp  <= tick.temp_tenths;
      in_data.value <= scan_slot[1] ? {1'b0, tick.minutes} : tick.hours;
      in_data.slot  <= scan_slot;
      in_data.dot   <= dot_lit;
    end
  end

  sssd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (scale_ready),
    .in_data   (in_data),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  sssd_encode u_encode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_valid),
    .in_ready (mid_ready),
    .in_data  (mid_data),
    .disp     (disp)
  );

`ifndef NO_ASSERTIONS
  // every accepted tick moves the scan to the next slot
  a_slot_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && !rst) |=> (scan_slot == 2'($past(scan_slot) + 2'd1)))
    else $error("scan slot did not advance on accepted transaction");

  // blink phase only changes at the end of a frame
  a_phase_frame_end: assert property (@(posedge clk) disable iff (rst)
    (!rst && !(accept && scan_slot == SLOT_UNITS)) |=> $stable(blink_phase))
    else $error("blink phase changed outside a frame end");

  // a valid display transaction selects exactly one of the four upper digit lines
  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    disp.valid |-> ($onehot(disp.digit_select) && (disp.digit_select[3:0] == 4'd0)))
    else $error("digit select not one-hot on a valid position");
`endif

endmodule

`default_nettype wire

/* test/sssd_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the seven segment scan driver: predicts every display transaction
// from the accepted tick transactions and compares it field by field
// depends on sssd_pkg (slot, select and segment constants) and sssd_if (channels)
module sssd_checker
  import sssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  sssd_in_if         tick,
  sssd_out_if        disp,
  output int         fail_count,
  output int         pending
);

  localparam int REPORT_LIMIT = 10;

  // segment patterns for digits 9 down to 0
  localparam logic [9:0][7:0] DIGIT_SEGS = {
    8'hf6, 8'hfe, 8'he0, 8'hbe, 8'hb6, 8'h66, 8'hf2, 8'hda, 8'h60, 8'hfc
  };

  typedef struct packed {
    logic [7:0] sel;
    logic [7:0] upper;
    logic [7:0] lower;
  } scan_frame_t;

  scan_frame_t frame_q[$];

  logic [1:0] scan_pos;
  logic [7:0] frames_done;
  logic       dots_dark;
  logic [7:0] blink_frames;

  function automatic scan_frame_t frame_for(input logic [14:0] temp, input logic [6:0] hours,
                                            input logic [5:0] minutes, input logic running);
    scan_frame_t f;
    int          mag;
    logic        negative;
    logic [7:0]  dot;
    negative = temp[14];
    mag = negative ? 32768 - int'(temp) : int'(temp);
    dot = (running && (hours != 0 || minutes != 0) && dots_dark) ? 8'h00 : SEG_DOT;
    case (scan_pos)
      SLOT_THOUSANDS: begin
        f.sel   = SEL_SLOT0;
        f.upper = negative ? SEG_MINUS : DIGIT_SEGS[(mag / 1000) % 10];
        f.lower = DIGIT_SEGS[(int'(hours) % 100) / 10];
      end
      SLOT_HUNDREDS: begin
        f.sel   = SEL_SLOT1;
        f.upper = DIGIT_SEGS[(mag / 100) % 10];
        f.lower = DIGIT_SEGS[int'(hours) % 10] | dot;
      end
      SLOT_TENS: begin
        f.sel   = SEL_SLOT2;
        f.upper = DIGIT_SEGS[(mag / 10) % 10] | SEG_DOT;
        f.lower = DIGIT_SEGS[(int'(minutes) % 100) / 10];
      end
      default: begin
        f.sel   = SEL_SLOT3;
        f.upper = DIGIT_SEGS[mag % 10];
        f.lower = DIGIT_SEGS[int'(minutes) % 10] | dot;
      end
    endcase
    return f;
  endfunction

  always @(posedge clk) begin
    scan_frame_t want;
    int          limit;
    if (rst) begin
      frame_q.delete();
      scan_pos     = SLOT_THOUSANDS;
      frames_done  = '0;
      dots_dark    = 1'b0;
      blink_frames = BLINK_HALF_RESET;
      fail_count   = 0;
      pending      = 0;
    end else begin
      if (disp.valid && disp.ready) begin
        if (frame_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected display transaction sel %h upper %h lower %h", $realtime,
                     disp.digit_select, disp.upper_segments, disp.lower_segments);
        end else begin
          want = frame_q.pop_front();
          if (want.sel !== disp.digit_select || want.upper !== disp.upper_segments ||
              want.lower !== disp.lower_segments) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch sel %h/%h upper %h/%h lower %h/%h (expected/actual)",
                       $realtime, want.sel, disp.digit_select, want.upper,
                       disp.upper_segments, want.lower, disp.lower_segments);
          end
        end
      end
      if (cfg_wr_en)
        blink_frames = cfg_wr_data;
      if (tick.valid && tick.ready) begin
        frame_q.push_back(frame_for(tick.temp_tenths, tick.hours, tick.minutes, tick.running));
        // frame ends after the units slot; a zero period behaves as one
        if (scan_pos == SLOT_UNITS) begin
          limit = (blink_frames == 0) ? 1 : int'(blink_frames);
          if (int'(frames_done) + 1 >= limit) begin
            frames_done = '0;
            dots_dark   = ~dots_dark;
          end else begin
            frames_done = frames_done + 8'd1;
          end
        end
        scan_pos = scan_pos + 2'd1;
      end
      pending = frame_q.size();
    end
  end

endmodule

/* test/tb_seven_segment_scan_driver_unit.sv */
`timescale 1ns / 1ps
// testbench top for the seven segment scan driver: clock, reset, tick and display
// traffic with random idling, blink period register writes and the verdict
// depends on sssd_pkg, sssd_if, sssd_checker and the block itself
module tb_seven_segment_scan_driver_unit;
  import sssd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 12;      // pipeline is three stages deep
  localparam int HOLD_CYCLES  = 300;     // long display stall to back up the pipe
  localparam int IDLE_MAX     = 12;

  typedef struct packed {
    logic [14:0] temp;
    logic [6:0]  hours;
    logic [5:0]  minutes;
    logic        running;
  } scan_tick_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         send_idle_max;
  int         recv_idle_max;
  logic       hold_req;

  sssd_in_if  tick_ch ();
  sssd_out_if disp_ch ();

  seven_segment_scan_driver_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick        (tick_ch),
    .disp        (disp_ch)
  );

  sssd_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick        (tick_ch),
    .disp        (disp_ch),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // watchdog: a hung handshake or lost display transaction ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic scan_tick_t make_tick(input int t, input int h, input int m, input bit r);
    scan_tick_t s;
    s.temp    = t[14:0];
    s.hours   = h[6:0];
    s.minutes = m[5:0];
    s.running = r;
    return s;
  endfunction

  // mostly plausible readings, some raw field noise, some zero times
  function automatic scan_tick_t random_tick();
    scan_tick_t s;
    int         t;
    if ($urandom_range(0, 3) != 0) t = int'($urandom_range(0, 10998)) - 999;
    else t = int'($urandom_range(0, 32767));
    s.temp    = t[14:0];
    s.hours   = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 99)) : 7'($urandom_range(0, 127));
    s.minutes = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 59)) : 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) == 0) begin
      s.hours   = '0;
      s.minutes = '0;
    end
    s.running = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(input scan_tick_t s);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      tick_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid       = 1'b1;
    tick_ch.temp_tenths = s.temp;
    tick_ch.hours       = s.hours;
    tick_ch.minutes     = s.minutes;
    tick_ch.running     = s.running;
    do @(posedge clk); while (!tick_ch.ready);
    @(negedge clk);
  endtask

  // stop offering ticks and let every expected transaction drain out
  task automatic wait_idle();
    tick_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_half_period(input logic [7:0] v);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic run_random(input int count, input bit with_hold);
    for (int i = 0; i < count; i++) begin
      // switch between idle-free bursts and gappy traffic
      if (i % 64 == 0) send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      if (with_hold && i == count / 4) hold_req = 1'b1;
      send_tick(random_tick());
    end
  endtask

  // display side: random stalls per transaction, one long hold on request
  initial begin
    int stall;
    int taken;
    disp_ch.ready = 1'b0;
    recv_idle_max = IDLE_MAX;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      if (hold_req) begin
        hold_req = 1'b0;
        disp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = $urandom_range(0, recv_idle_max);
      if (stall > 0) begin
        disp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      disp_ch.ready = 1'b1;
      do @(posedge clk); while (!disp_ch.valid);
      @(negedge clk);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    scan_tick_t directed [24];
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    hold_req            = 1'b0;
    send_idle_max       = IDLE_MAX;
    tick_ch.valid       = 1'b0;
    tick_ch.temp_tenths = '0;
    tick_ch.hours       = '0;
    tick_ch.minutes     = '0;
    tick_ch.running     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // field extremes, spread so most land on several slots: negative values with
    // the minus sign, the most negative raw value, out of range temperature,
    // hours and minutes, zero time while running
    directed = '{
      make_tick(0, 0, 0, 0),        make_tick(9999, 99, 59, 1),
      make_tick(-999, 12, 34, 1),   make_tick(-1, 0, 0, 1),
      make_tick(16383, 127, 63, 1), make_tick(-16384, 100, 60, 0),
      make_tick(1234, 23, 45, 1),   make_tick(-5, 9, 9, 0),
      make_tick(9999, 0, 1, 1),     make_tick(-999, 1, 0, 1),
      make_tick(10000, 127, 0, 0),  make_tick(-1000, 0, 63, 1),
      make_tick(-16384, 99, 59, 1), make_tick(16383, 0, 0, 0),
      make_tick(5678, 7, 8, 1),     make_tick(-250, 50, 30, 0),
      make_tick(999, 119, 61, 1),   make_tick(-16384, 127, 63, 0),
      make_tick(12345, 10, 10, 1),  make_tick(-99, 0, 0, 0),
      make_tick(1, 45, 6, 1),       make_tick(-10, 88, 47, 0),
      make_tick(9000, 64, 32, 1),   make_tick(-16383, 1, 1, 1)
    };
    foreach (directed[i]) send_tick(directed[i]);

    run_random(150, 1'b0);       // reset blink period
    write_half_period(8'd1);     // shortest legal period
    run_random(150, 1'b0);
    write_half_period(8'd0);     // zero behaves as one
    run_random(150, 1'b0);
    write_half_period(8'd255);   // longest period, one toggle inside the phase
    run_random(1100, 1'b1);
    write_half_period(8'd3);     // lowered below the running frame count
    run_random(100, 1'b0);
    write_half_period(8'd7);
    run_random(100, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sssd_pkg.sv
rtl/sssd_if.sv
rtl/sssd_scale.sv
rtl/sssd_encode.sv
rtl/seven_segment_scan_driver_unit.sv
test/sssd_checker.sv
test/tb_seven_segment_scan_driver_unit.sv
